/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Condition that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

`endif

/* rtl/lrukv_pkg.sv */
// Package for the LRU key-value cache: sizes, field types, sequencer states.
// Depends on nothing; imported by the cache unit and the testbench.
package lrukv_pkg;
	localparam int Entries = 128;
	localparam int IdxW = $clog2(Entries);
	localparam int CntW = $clog2(Entries + 1);
	localparam int KeyW = 32;
	localparam int ValW = 32;
	localparam int CapW = 8;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_SET = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVICT,
		ST_FREE,
		ST_RANK,
		ST_FINISH,
		ST_OUT
	} state_t;
endpackage

/* rtl/lrukv_ram.sv */
// Generic single-port-write, one-read synchronous RAM with registered read.
// Depends on nothing; used for every store of the cache.
module lrukv_ram #(
	parameter int Width = 32,
	parameter int Depth = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/lru_key_value_cache_unit.sv */
// LRU key-value cache, one request at a time. A key scan runs over the entry
// memories one slot a cycle; a get miss then raises its result. A new insert
// evicts the least recent entry by a scan when full and takes the lowest free
// slot; a hit or insert then runs a rank pass one slot a cycle. The input stays
// stalled until the result beat is taken. The store starts empty right after
// reset, with no clearing pass; the result register frees the input once read.
// Depends on lrukv_pkg, lrukv_ram and assert_macros.svh.
`include "assert_macros.svh"
module lru_key_value_cache_unit
	import lrukv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CapW-1:0]        cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic signed [KeyW-1:0] key,
	input  logic signed [ValW-1:0] write_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic signed [ValW-1:0] read_value
);
	state_t state_q, state_d;
	logic [CapW-1:0] cap_q;
	logic [Entries-1:0] valid_q;
	logic [CntW-1:0] count_q;
	logic cmd_q;
	logic [KeyW-1:0] key_q;
	logic [ValW-1:0] wval_q;
	logic [CntW-1:0] ptr_q;       // issue pointer, holds Entries at end
	logic [IdxW-1:0] ridx_s1;     // slot whose data is on the read port
	logic rv_s1;                  // read data valid
	logic found_q;
	logic [IdxW-1:0] slot_q;
	logic [IdxW-1:0] trank_q;     // rank of touched entry
	logic ins_q;                  // request is an insert
	logic out_valid_q, hit_q;
	logic [ValW-1:0] rval_q;

	// memories
	logic [KeyW-1:0] key_rd;
	logic [ValW-1:0] val_rd;
	logic [IdxW-1:0] rank_rd;
	logic key_we, val_we, rank_we;
	logic [IdxW-1:0] rank_waddr, wr_addr, raddr;
	logic [IdxW-1:0] rank_wdata;

	lrukv_ram #(.Width(KeyW), .Depth(Entries)) u_keys (
		.clk(clk), .we(key_we), .waddr(wr_addr), .wdata(key_q),
		.raddr(raddr), .rdata(key_rd));
	lrukv_ram #(.Width(ValW), .Depth(Entries)) u_vals (
		.clk(clk), .we(val_we), .waddr(wr_addr), .wdata(wval_q),
		.raddr(raddr), .rdata(val_rd));
	lrukv_ram #(.Width(IdxW), .Depth(Entries)) u_ranks (
		.clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
		.raddr(raddr), .rdata(rank_rd));

	// effective capacity clamped to 1..Entries
	logic [CntW-1:0] eff_cap;
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CntW'(1);
		end else if (32'(cap_q) > Entries) begin
			eff_cap = CntW'(Entries);
		end else begin
			eff_cap = CntW'(cap_q);
		end
	end

	logic ptr_end;
	logic cur_valid;
	assign ptr_end = (ptr_q == CntW'(Entries));
	assign raddr = ptr_q[IdxW-1:0];
	assign cur_valid = valid_q[ridx_s1];
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign read_value = rval_q;

	// rank update for the entry on the read port, and rank zero for the touched slot on finish
	always_comb begin
		rank_we = 1'b0;
		rank_waddr = ridx_s1;
		rank_wdata = rank_rd + IdxW'(1);
		if (state_q == ST_RANK && rv_s1 && cur_valid) begin
			if (ins_q) begin
				rank_we = 1'b1;
			end else if (rank_rd < trank_q) begin
				rank_we = 1'b1;
			end
		end
		if (state_q == ST_FINISH) begin
			rank_we = 1'b1;
			rank_waddr = slot_q;
			rank_wdata = '0;
		end
	end

	assign wr_addr = slot_q;
	assign key_we = (state_q == ST_FINISH) && ins_q;
	assign val_we = (state_q == ST_FINISH) && cmd_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN: begin
				if (rv_s1 && cur_valid && key_rd == key_q) begin
					state_d = ST_RANK;
				end else if (ptr_end && !rv_s1) begin
					if (cmd_q == CMD_SET) begin
						state_d = (count_q >= eff_cap) ? ST_EVICT : ST_FREE;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_EVICT: begin
				if ((rv_s1 && cur_valid && CntW'(rank_rd) == count_q - CntW'(1))
						|| (ptr_end && !rv_s1)) begin
					state_d = ST_FREE;
				end
			end
			ST_FREE:   state_d = ST_RANK;
			ST_RANK:   if (ptr_end && !rv_s1) state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// lowest free slot
	logic [IdxW-1:0] free_idx;
	always_comb begin
		free_idx = '0;
		for (int i = Entries - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_idx = IdxW'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q <= CapW'(Entries);
			valid_q <= '0;
			count_q <= '0;
			ptr_q <= '0;
			rv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_wdata;
			// read pointer runs while the state holds, restarts on state change
			if (state_d != state_q) begin
				ptr_q <= '0;
				rv_s1 <= 1'b0;
			end else if (!ptr_end) begin
				ptr_q <= ptr_q + CntW'(1);
				rv_s1 <= 1'b1;
			end else begin
				rv_s1 <= 1'b0;
			end
			if (state_q == ST_EVICT && state_d == ST_FREE && rv_s1 && cur_valid
					&& CntW'(rank_rd) == count_q - CntW'(1)) begin
				valid_q[ridx_s1] <= 1'b0;
				count_q <= count_q - CntW'(1);
			end
			if (state_q == ST_FINISH && ins_q) begin
				valid_q[slot_q] <= 1'b1;
				count_q <= count_q + CntW'(1);
			end
			if (state_q == ST_FINISH || (state_q == ST_SCAN && state_d == ST_OUT)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ridx_s1 <= ptr_q[IdxW-1:0];
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= cmd;
			key_q <= key;
			wval_q <= write_value;
			found_q <= 1'b0;
			ins_q <= 1'b0;
			rval_q <= '0;
		end
		if (state_q == ST_SCAN && state_d == ST_RANK) begin
			found_q <= 1'b1;
			slot_q <= ridx_s1;
			trank_q <= rank_rd;
			if (cmd_q == CMD_GET) rval_q <= val_rd;
		end
		if (state_q == ST_FREE) begin
			ins_q <= 1'b1;
			slot_q <= free_idx;
		end
		if (state_q == ST_FINISH || (state_q == ST_SCAN && state_d == ST_OUT)) begin
			hit_q <= found_q;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CntW'(Entries))
	`ASSERT_IMPL(a_busy_no_ready, clk, arst_n, state_q != ST_IDLE, !in_ready)
	`ASSERT_IMPL(a_get_no_insert, clk, arst_n, ins_q && state_q == ST_RANK, cmd_q == CMD_SET)
endmodule

/* tb/lru_key_value_cache_unit_test.sv */
// Testbench for the LRU key-value cache: directed and random get/set beats,
// scored against an in-bench LRU store model. Depends on lrukv_pkg and the RTL.
`timescale 1ns / 100ps

class lru_store_board;
	logic [31:0] store_keys[$];   // index 0 is the most recent entry
	logic [31:0] store_values[$];
	int unsigned cap_reg;
	logic        want_hit[$];
	logic [31:0] want_value[$];
	int          errors;

	function void clear();
		store_keys.delete();
		store_values.delete();
		want_hit.delete();
		want_value.delete();
		cap_reg = 128;
		errors = 0;
	endfunction

	function void set_capacity(int unsigned c);
		cap_reg = c & 8'hff;
	endfunction

	// Apply one accepted request and queue its expected result.
	function void note_request(logic c, logic [31:0] k, logic [31:0] v);
		int found;
		int eff;
		logic [31:0] rd;
		found = -1;
		rd = 0;
		eff = cap_reg;
		if (eff < 1) eff = 1;
		if (eff > lrukv_pkg::Entries) eff = lrukv_pkg::Entries;
		foreach (store_keys[i])
			if (found < 0 && store_keys[i] == k) found = i;
		if (found >= 0) begin
			if (c == lrukv_pkg::CMD_GET) rd = store_values[found];
			else store_values[found] = v;
			k = store_keys[found];
			v = store_values[found];
			store_keys.delete(found);
			store_values.delete(found);
			store_keys.insert(0, k);
			store_values.insert(0, v);
		end else if (c == lrukv_pkg::CMD_SET) begin
			if (store_keys.size() >= eff && store_keys.size() > 0) begin
				// drop the least recent entry
				store_keys.delete(store_keys.size() - 1);
				store_values.delete(store_values.size() - 1);
			end
			store_keys.insert(0, k);
			store_values.insert(0, v);
		end
		want_hit.insert(want_hit.size(), found >= 0);
		want_value.insert(want_value.size(), rd);
	endfunction

	function void check_result(logic h, logic [31:0] rv);
		logic eh;
		logic [31:0] ev;
		if (want_hit.size() == 0) begin
			$error("result with no request outstanding: hit=%0d read_value=%h", h, rv);
			errors++;
			return;
		end
		eh = want_hit.pop_front();
		ev = want_value.pop_front();
		if (h !== eh) begin
			$error("hit: expected %0d actual %0d", eh, h);
			errors++;
		end
		if (rv !== ev) begin
			$error("read_value: expected %h actual %h", ev, rv);
			errors++;
		end
	endfunction
endclass

module lru_key_value_cache_unit_test;
	import lrukv_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CapW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic signed [KeyW-1:0] key = '0;
	logic signed [ValW-1:0] write_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic signed [ValW-1:0] read_value;

	lru_store_board board;
	bit quiet_tail = 1'b0;   // no idling in the last part of the run
	bit hold_off = 1'b0;     // long receiver stall requested
	int idle_cycles = 0;
	logic [31:0] key_pool[16];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lru_key_value_cache_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .key(key), .write_value(write_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .read_value(read_value)
	);

	// Score every accepted beat on both channels.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_request(cmd, key, write_value);
		if (arst_n && out_valid && out_ready) board.check_result(hit, read_value);
	end

	// Watchdog: cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 15);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Valid stays up after an accepted beat; the next request may lower it for a random gap, and drain lowers it.
	task automatic send_request(logic c, logic [31:0] k, logic [31:0] v);
		int n;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		key <= k;
		write_value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.want_hit.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_capacity(logic [7:0] c);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_capacity(c);
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 15)];
		return $urandom();
	endfunction

	task automatic random_phase(int count, int nkeys);
		for (int i = 0; i < count; i++)
			send_request(logic'($urandom_range(0, 1)),
				key_pool[$urandom_range(0, nkeys - 1)] ^
				(($urandom_range(0, 19) == 0) ? $urandom() : 32'h0),
				$urandom());
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme keys and values, get miss, set insert, update, get hit.
		send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(CMD_SET, 32'h0, 32'hFFFF_FFFF);
		send_request(CMD_SET, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_GET, 32'h8000_0000, 32'h0);
		send_request(CMD_SET, 32'h7FFF_FFFF, 32'h1234_5678);
		send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
		send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
		send_request(CMD_GET, 32'h0, 32'h0);
		drain();

		// Capacity zero acts as one; then capacity three, filled past it by five inserts.
		write_capacity(8'd0);
		send_request(CMD_SET, 32'h11, 32'hA);
		send_request(CMD_GET, 32'h0, 32'h0);
		send_request(CMD_GET, 32'h11, 32'h0);
		drain();
		write_capacity(8'd3);
		for (int i = 0; i < 5; i++) send_request(CMD_SET, 32'h100 + i, i);
		send_request(CMD_GET, 32'h100, 32'h0);
		send_request(CMD_GET, 32'h102, 32'h0);
		drain();

		// Random phases over several capacities, extremes among them.
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
		write_capacity(8'd4);
		random_phase(200, 8);
		drain();
		write_capacity(8'd255);
		// Sender keeps offering while the receiver holds off.
		hold_off = 1'b1;
		random_phase(300, 16);
		drain();
		write_capacity(8'd1);
		random_phase(200, 4);
		drain();
		write_capacity(8'd128);
		for (int i = 0; i < 300; i++)
			send_request(logic'($urandom_range(0, 1)), pick_key(), $urandom());
		drain();
		write_capacity(8'd129);
		random_phase(150, 16);
		drain();
		quiet_tail = 1'b1;
		write_capacity(8'd7);
		random_phase(170, 12);
		drain();

		if (board.errors == 0 && board.want_hit.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/lrukv_pkg.sv
rtl/lrukv_ram.sv
rtl/lru_key_value_cache_unit.sv
tb/lru_key_value_cache_unit_test.sv
